// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSD_NEVER(lbl, cond, msg) `LSD_ASSERT(lbl, !(cond), msg)
`else
`define LSD_ASSERT(lbl, prop, msg)
`define LSD_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/lsd_pkg.sv -----
// Types and codes shared by the linked slot deque.
package lsd_pkg;

  localparam logic [2:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [2:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [2:0] OP_READ_FIRST = 3'd2;
  localparam logic [2:0] OP_READ_LAST = 3'd3;
  localparam logic [2:0] OP_READ_AT = 3'd4;
  localparam logic [2:0] OP_CLEAN = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_WALK_NX,
    S_RD_ISS,
    S_RD_USE,
    S_UL_ISS,
    S_UL_USE,
    S_PUSH_A,
    S_PUSH_B,
    S_SCAN
  } lsd_state_t;

  // Write enables of the three slot memories.
  typedef struct packed {
    logic data_we;
    logic next_we;
    logic prev_we;
  } lsd_we_t;

endpackage

// ----- rtl/core/lsd_slot_mem.sv -----
// Slot pool memories: payload, next link and prev link, each with one registered read.
module lsd_slot_mem
  import lsd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW = $clog2(DEPTH),
  parameter int LW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data,
  output logic [LW-1:0]         rd_next,
  output logic [LW-1:0]         rd_prev,
  input  lsd_we_t               we,
  input  logic [AW-1:0]         data_waddr,
  input  logic [DATA_WIDTH-1:0] data_wdata,
  input  logic [AW-1:0]         next_waddr,
  input  logic [LW-1:0]         next_wdata,
  input  logic [AW-1:0]         prev_waddr,
  input  logic [LW-1:0]         prev_wdata
);

  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic [LW-1:0]         next_mem [DEPTH];
  logic [LW-1:0]         prev_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    rd_data <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    rd_prev <= prev_mem[rd_addr];
  end

endmodule

// ----- rtl/core/linked_slot_deque.sv -----
// Top level of the linked slot deque: control sequencer around the slot memories.
//
// The deque is a doubly linked list kept in a pool of DEPTH slots held in three
// synchronous memories (payload, next link, prev link), each with a registered
// read. One request is worked at a time: busy is high from the cycle after start
// is taken until the result appears. Every request produces exactly one result,
// shown for a single cycle with out_valid high; the receiver cannot hold it off,
// so it must sample it in that cycle. A new request may be started in the cycle
// the result is shown. A read at position P follows the next links from the
// head and stops early when the list ends; each hop along the list waits on a
// memory read of the next link. A push links the free slot in, then scans for
// the next free slot, checking one slot per cycle from slot zero up to the first
// unlinked slot below capacity; on a full pool, force first drops the item at
// the opposite end. The capacity register is written through the cfg channel,
// which is ready only while idle; a write empties the deque, like clean.
module linked_slot_deque
  import lsd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic        in_force_req,
  input  logic        in_remove,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  output logic        out_ok,
  output logic [31:0] out_data_out,
  output logic [6:0]  out_item_count,
  output logic        out_is_full,
  output logic        out_is_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_capacity
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > 7) ? LW : 7;
  // A link equal to DEPTH means "no slot".
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  lsd_state_t state_r, state_nxt;

  logic [LW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    tail_r, tail_nxt;
  logic [LW-1:0]    free_r, free_nxt;
  logic [LW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    cap_r, cap_nxt;
  logic [LW-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]    scan_r, scan_nxt;
  logic [6:0]       hop_r, hop_nxt;
  logic [DEPTH-1:0] linked_r, linked_nxt;

  // Request captured at start.
  logic [2:0]  op_r;
  logic        force_r;
  logic        rem_r;
  logic [6:0]  pos_r;
  logic [31:0] din_r;

  logic        out_valid_r;
  logic        out_ok_r;
  logic [31:0] out_data_r;
  logic [6:0]  out_count_r;
  logic        out_full_r;
  logic        out_empty_r;

  // Result of the current cycle, registered onto the output ports.
  logic        emit;
  logic        res_ok;
  logic [31:0] res_data;

  // Memory ports.
  logic [DATA_WIDTH-1:0] rd_data;
  logic [LW-1:0]         rd_next, rd_prev;
  lsd_we_t               we;
  logic [AW-1:0]         data_waddr, next_waddr, prev_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [LW-1:0]         next_wdata, prev_wdata;

  logic [DATA_WIDTH+31:0] din_ext;
  logic [DATA_WIDTH+31:0] dout_ext;
  logic [LW+6:0]          count_ext;
  logic [CW-1:0]          cfg_ext;
  logic                   cfg_fire;
  logic                   do_unlink;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ext   = CW'(cfg_capacity);

  // Payload is kept to DATA_WIDTH bits and read back zero-extended to 32.
  assign din_ext    = {{DATA_WIDTH{1'b0}}, din_r};
  assign data_wdata = din_ext[DATA_WIDTH-1:0];
  assign dout_ext   = {32'd0, rd_data};
  assign count_ext  = {7'd0, count_nxt};

  lsd_slot_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk        (clk),
    .rd_addr    (cur_r[AW-1:0]),
    .rd_data    (rd_data),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .we         (we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    cur_nxt    = cur_r;
    scan_nxt   = scan_r;
    hop_nxt    = hop_r;
    linked_nxt = linked_r;
    emit       = 1'b0;
    res_ok     = 1'b0;
    res_data   = 32'd0;
    do_unlink  = 1'b0;
    we         = '0;
    data_waddr = cur_r[AW-1:0];
    next_waddr = cur_r[AW-1:0];
    prev_waddr = cur_r[AW-1:0];
    next_wdata = NIL;
    prev_wdata = NIL;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end else if (cfg_fire) begin
          // Out-of-range capacity is clamped; the deque is emptied.
          if (cfg_ext == '0) begin
            cap_nxt = LW'(1);
          end else if (cfg_ext > CW'(DEPTH)) begin
            cap_nxt = NIL;
          end else begin
            cap_nxt = cfg_ext[LW-1:0];
          end
          head_nxt   = NIL;
          tail_nxt   = NIL;
          free_nxt   = '0;
          count_nxt  = '0;
          linked_nxt = '0;
        end
      end

      S_DISPATCH: begin
        unique case (op_r)
          OP_PUSH_TAIL, OP_PUSH_HEAD: begin
            if (free_r != NIL) begin
              state_nxt = S_PUSH_A;
            end else begin
              // Pool is full: a forced push first drops the opposite end.
              cur_nxt = (op_r == OP_PUSH_TAIL) ? head_r : tail_r;
              if (force_r && (cur_nxt != NIL)) begin
                state_nxt = S_UL_ISS;
              end else begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          end
          OP_READ_FIRST: begin
            cur_nxt   = head_r;
            state_nxt = S_RD_ISS;
          end
          OP_READ_LAST: begin
            cur_nxt   = tail_r;
            state_nxt = S_RD_ISS;
          end
          OP_READ_AT: begin
            if (pos_r == 7'd0) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cur_nxt   = head_r;
              hop_nxt   = 7'd1;
              state_nxt = S_WALK;
            end
          end
          OP_CLEAN: begin
            head_nxt   = NIL;
            tail_nxt   = NIL;
            free_nxt   = '0;
            count_nxt  = '0;
            linked_nxt = '0;
            emit       = 1'b1;
            res_ok     = 1'b1;
            state_nxt  = S_IDLE;
          end
          default: begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Follow next links until the requested position or the list end.
      S_WALK: begin
        if ((cur_r == NIL) || (hop_r >= pos_r)) begin
          state_nxt = S_RD_ISS;
        end else begin
          state_nxt = S_WALK_NX;
        end
      end

      S_WALK_NX: begin
        cur_nxt   = rd_next;
        hop_nxt   = hop_r + 7'd1;
        state_nxt = S_WALK;
      end

      S_RD_ISS: begin
        if (cur_r == NIL) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD_USE;
        end
      end

      S_RD_USE: begin
        emit      = 1'b1;
        res_ok    = 1'b1;
        res_data  = dout_ext[31:0];
        do_unlink = rem_r;
        state_nxt = S_IDLE;
      end

      S_UL_ISS: begin
        state_nxt = S_UL_USE;
      end

      S_UL_USE: begin
        do_unlink = 1'b1;
        state_nxt = S_PUSH_A;
      end

      // Link the free slot in; the neighbor's link is written next cycle.
      S_PUSH_A: begin
        cur_nxt                       = free_r;
        we.data_we                    = 1'b1;
        we.next_we                    = 1'b1;
        we.prev_we                    = 1'b1;
        data_waddr                    = free_r[AW-1:0];
        next_waddr                    = free_r[AW-1:0];
        prev_waddr                    = free_r[AW-1:0];
        linked_nxt[free_r[AW-1:0]]    = 1'b1;
        count_nxt                     = count_r + LW'(1);
        scan_nxt                      = '0;
        if (head_r == NIL) begin
          head_nxt  = free_r;
          tail_nxt  = free_r;
          state_nxt = S_SCAN;
        end else if (op_r == OP_PUSH_TAIL) begin
          prev_wdata = tail_r;
          state_nxt  = S_PUSH_B;
        end else begin
          next_wdata = head_r;
          state_nxt  = S_PUSH_B;
        end
      end

      S_PUSH_B: begin
        if (op_r == OP_PUSH_TAIL) begin
          we.next_we = 1'b1;
          next_waddr = tail_r[AW-1:0];
          next_wdata = cur_r;
          tail_nxt   = cur_r;
        end else begin
          we.prev_we = 1'b1;
          prev_waddr = head_r[AW-1:0];
          prev_wdata = cur_r;
          head_nxt   = cur_r;
        end
        state_nxt = S_SCAN;
      end

      // Lowest unlinked slot below capacity, one slot per cycle.
      S_SCAN: begin
        if (scan_r >= cap_r) begin
          free_nxt  = NIL;
          emit      = 1'b1;
          res_ok    = 1'b1;
          state_nxt = S_IDLE;
        end else if (!linked_r[scan_r[AW-1:0]]) begin
          free_nxt  = scan_r;
          emit      = 1'b1;
          res_ok    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + LW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Unlink the slot in cur_r using the links read in the previous cycle.
    if (do_unlink) begin
      if (rd_prev == NIL) begin
        head_nxt = rd_next;
      end else begin
        we.next_we = 1'b1;
        next_waddr = rd_prev[AW-1:0];
        next_wdata = rd_next;
      end
      if (rd_next == NIL) begin
        tail_nxt = rd_prev;
      end else begin
        we.prev_we = 1'b1;
        prev_waddr = rd_next[AW-1:0];
        prev_wdata = rd_prev;
      end
      linked_nxt[cur_r[AW-1:0]] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - LW'(1);
      end
      if (free_r == NIL) begin
        free_nxt = cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      free_r      <= '0;
      count_r     <= '0;
      cap_r       <= NIL;
      linked_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      linked_r    <= linked_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    scan_r <= scan_nxt;
    hop_r  <= hop_nxt;
    if (start && !busy) begin
      op_r    <= in_op;
      force_r <= in_force_req;
      rem_r   <= in_remove;
      pos_r   <= in_position;
      din_r   <= in_data_in;
    end
    if (emit) begin
      out_ok_r    <= res_ok;
      out_data_r  <= res_data;
      out_count_r <= count_ext[6:0];
      out_full_r  <= (free_nxt == NIL);
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_data_out   = out_data_r;
  assign out_item_count = out_count_r;
  assign out_is_full    = out_full_r;
  assign out_is_empty   = out_empty_r;

  `LSD_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe held two cycles")
  `LSD_ASSERT(a_count_cap, count_r <= cap_r, "item count above capacity")
  `LSD_ASSERT(a_empty_head, (count_r == '0) == (head_r == NIL), "count and head disagree")
  `LSD_NEVER(a_cfg_busy, cfg_fire && (state_r != S_IDLE), "capacity written while busy")

endmodule
